/* sv/pbr_pkg.sv */
// Shared widths, codes, data types and rounding helper of the pose blend pipeline.
`timescale 1ns / 1ps
package pbr_pkg;

  localparam int TRANSLATION_BITS = 20;
  localparam int ROTATION_BITS    = 15;
  localparam int SCALE_BITS       = 16;

  localparam int TRN_W   = 3 * TRANSLATION_BITS;
  localparam int ROT_W   = 4 * ROTATION_BITS;
  localparam int SCL_W   = 3 * SCALE_BITS;
  localparam int WGT_W   = 16;
  localparam int TIME_W  = 16;
  localparam int DELTA_W = 14;

  localparam logic [WGT_W-1:0]   WEIGHT_ONE   = 16'h8000;
  localparam logic [TIME_W-1:0]  MAX_DURATION = 16'd60000;
  localparam logic [DELTA_W-1:0] MAX_DELTA    = 14'd10000;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BONE  = 1'b1;

  typedef enum logic [1:0] {
    MODE_ANIM    = 2'd0,
    MODE_PHYS    = 2'd1,
    MODE_TO_PHYS = 2'd2,
    MODE_TO_ANIM = 2'd3
  } mode_t;

  // Weight divider: one quotient bit per step.
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = WGT_W / DIV_PER_STAGE;
  localparam int NUM_W         = 2 * TIME_W;
  localparam int DEN_W         = TIME_W + 1;
  localparam int PEND_W        = $clog2(DIV_STAGES + 4);

  // Lerp datapath.
  localparam int WS_W  = WGT_W + 1;
  localparam int DT_W  = TRANSLATION_BITS + 1;
  localparam int DS_W  = SCALE_BITS + 1;
  localparam int DR_W  = ROTATION_BITS + 2;
  localparam int DP_W  = 2 * ROTATION_BITS;
  localparam int DMAX  = (DT_W > DS_W) ? ((DT_W > DR_W) ? DT_W : DR_W)
                                       : ((DS_W > DR_W) ? DS_W : DR_W);
  localparam int PRD_W = DMAX + WS_W;

  // Quaternion normalization.
  localparam int C_W        = ROTATION_BITS + 1;
  localparam int SQ_W       = 2 * C_W;
  localparam int N2_W       = SQ_W + 2;
  localparam int CAND_W     = 4 * ROTATION_BITS + 4;
  localparam int Q_W        = ROTATION_BITS - 1;
  localparam int NORM_STEPS = ROTATION_BITS - 1;
  localparam int UNIT_SH    = ROTATION_BITS - 2;

  typedef struct packed {
    logic [TRN_W-1:0] a_trn;
    logic [ROT_W-1:0] a_rot;
    logic [SCL_W-1:0] a_scl;
    logic [TRN_W-1:0] b_trn;
    logic [ROT_W-1:0] b_rot;
    logic [SCL_W-1:0] b_scl;
    logic [1:0]       mode;
    logic             frame_end;
  } bone_t;

  typedef struct packed {
    logic              upd;
    logic              bypass;
    logic              dir;
    logic [WGT_W-1:0]  base;
    logic [WGT_W-1:0]  d;
    logic [TIME_W-1:0] e;
    logic [TIME_W-1:0] len;
  } wop_t;

  typedef struct packed {
    logic [TRN_W-1:0] trn;
    logic [SCL_W-1:0] scl;
    logic [1:0]       mode;
    logic [WGT_W-1:0] weight;
    logic             frame_end;
  } res_t;

  // Divide by 2^15, rounding to nearest with ties away from zero.
  function automatic logic signed [PRD_W-1:0] round_q15(input logic signed [PRD_W-1:0] p);
    logic [PRD_W-1:0] mag;
    logic [PRD_W-1:0] r;
    mag = p[PRD_W-1] ? PRD_W'(-p) : PRD_W'(p);
    r   = (mag + (PRD_W'(1) << (WGT_W - 2))) >> (WGT_W - 1);
    return p[PRD_W-1] ? -$signed(r) : $signed(r);
  endfunction

endpackage

/* sv/pbr_ctrl.sv */
// Ramp state, request handshake and first pipeline register.
`timescale 1ns / 1ps
module pbr_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic                         command,
  input  logic                         enable,
  input  logic [pbr_pkg::TIME_W-1:0]   duration_ms,
  input  logic [pbr_pkg::DELTA_W-1:0]  delta_ms,
  input  logic                         last_bone,
  input  pbr_pkg::bone_t               bone_in,
  input  logic                         wb_upd,
  input  logic [pbr_pkg::WGT_W-1:0]    wb_weight,
  output logic                         s1_valid,
  output pbr_pkg::wop_t                s1_wop,
  output pbr_pkg::bone_t               s1_bone
);
  import pbr_pkg::*;

  mode_t              mode;
  mode_t              mode_bone;
  logic [WGT_W-1:0]   cur_weight;
  logic [WGT_W-1:0]   ramp_start;
  logic               ramp_target;
  logic [TIME_W-1:0]  ramp_length;
  logic [TIME_W-1:0]  ramp_elapsed;
  logic               frame_open;
  logic [PEND_W-1:0]  pend;

  logic               accept;
  logic               is_bone;
  logic               ramping;
  logic               advance;
  logic [TIME_W-1:0]  dur_sat;
  logic [DELTA_W-1:0] delta_sat;
  logic [TIME_W:0]    e_sum;
  logic [TIME_W-1:0]  e_new;
  logic [TIME_W-1:0]  e_use;
  logic [WGT_W-1:0]   tgt_new;
  logic [WGT_W-1:0]   tgt_cur;
  bone_t              bone_next;
  wop_t               wop_next;

  // A start command reads the current weight, so it waits until every
  // frame-advancing bone has left the divider.
  always_comb begin
    req_stall = !en || (command == CMD_START && pend != '0);
    accept    = req_valid && !req_stall;
    is_bone   = (command == CMD_BONE);
    ramping   = (mode == MODE_TO_PHYS) || (mode == MODE_TO_ANIM);
    advance   = is_bone && !frame_open && ramping;
    dur_sat   = (duration_ms > MAX_DURATION) ? MAX_DURATION : duration_ms;
    delta_sat = (delta_ms > MAX_DELTA) ? MAX_DELTA : delta_ms;
    e_sum     = {1'b0, ramp_elapsed} + (TIME_W + 1)'(delta_sat);
    e_new     = (e_sum > {1'b0, ramp_length}) ? ramp_length : e_sum[TIME_W-1:0];
    e_use     = advance ? e_new : ramp_elapsed;
    tgt_new   = enable ? WEIGHT_ONE : '0;
    tgt_cur   = ramp_target ? WEIGHT_ONE : '0;
    mode_bone = mode;
    if (advance && e_new >= ramp_length) begin
      mode_bone = ramp_target ? MODE_PHYS : MODE_ANIM;
    end
    bone_next           = bone_in;
    bone_next.mode      = mode_bone;
    bone_next.frame_end = last_bone;
    wop_next.upd        = advance;
    wop_next.bypass     = !ramping;
    wop_next.dir        = ramp_target;
    wop_next.base       = ramping ? ramp_start : tgt_cur;
    wop_next.d          = ramp_target ? (WEIGHT_ONE - ramp_start) : ramp_start;
    wop_next.e          = e_use;
    wop_next.len        = ramp_length;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_ANIM;
      cur_weight   <= '0;
      ramp_start   <= '0;
      ramp_target  <= 1'b0;
      ramp_length  <= '0;
      ramp_elapsed <= '0;
      frame_open   <= 1'b0;
      pend         <= '0;
      s1_valid     <= 1'b0;
    end else begin
      pend <= pend + PEND_W'(accept && advance) - PEND_W'(wb_upd);
      if (wb_upd) begin
        cur_weight <= wb_weight;
      end
      if (accept && !is_bone) begin
        ramp_start   <= cur_weight;
        ramp_target  <= enable;
        ramp_length  <= dur_sat;
        ramp_elapsed <= '0;
        frame_open   <= 1'b0;
        if (dur_sat == '0 || cur_weight == tgt_new) begin
          cur_weight <= tgt_new;
          mode       <= enable ? MODE_PHYS : MODE_ANIM;
        end else begin
          mode <= enable ? MODE_TO_PHYS : MODE_TO_ANIM;
        end
      end
      if (accept && is_bone) begin
        ramp_elapsed <= e_use;
        mode         <= mode_bone;
        frame_open   <= !last_bone;
      end
      if (en) begin
        s1_valid <= accept && is_bone;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_bone <= bone_next;
      s1_wop  <= wop_next;
    end
  end

endmodule

/* sv/pbr_wdiv.sv */
// Pipelined weight computation: product, restoring divider and final add.
`timescale 1ns / 1ps
module pbr_wdiv (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      s1_valid,
  input  pbr_pkg::wop_t             s1_wop,
  input  pbr_pkg::bone_t            s1_bone,
  output logic                      w_valid,
  output logic [pbr_pkg::WGT_W-1:0] w_weight,
  output pbr_pkg::bone_t            w_bone,
  output logic                      wb_upd,
  output logic [pbr_pkg::WGT_W-1:0] wb_weight
);
  import pbr_pkg::*;

  localparam int LAST = DIV_STAGES - 1;

  logic              p_valid;
  wop_t              p_wop;
  bone_t             p_bone;
  logic [NUM_W-1:0]  p_prod;

  logic              d_valid [DIV_STAGES];
  wop_t              d_wop   [DIV_STAGES];
  bone_t             d_bone  [DIV_STAGES];
  logic [DEN_W-1:0]  d_rem   [DIV_STAGES];
  logic [TIME_W-1:0] d_low   [DIV_STAGES];
  logic [WGT_W-1:0]  d_q     [DIV_STAGES];

  logic [DEN_W-1:0]  rem_next [DIV_STAGES];
  logic [TIME_W-1:0] low_next [DIV_STAGES];
  logic [WGT_W-1:0]  q_next   [DIV_STAGES];
  logic [WGT_W-1:0]  w_next;

  // Quotient of (2*d*e + len) / (2*len), two bits per stage. The quotient
  // never exceeds d, so the high half of the numerator starts below the divisor.
  always_comb begin
    logic [NUM_W-1:0]  num;
    logic [DEN_W:0]    r;
    logic [DEN_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [TIME_W-1:0] low;
    logic [WGT_W-1:0]  q;
    num = {p_prod[NUM_W-2:0], 1'b0} + NUM_W'(p_wop.len);
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (j == 0) begin
        rem = {1'b0, num[NUM_W-1:TIME_W]};
        low = num[TIME_W-1:0];
        q   = '0;
        den = {p_wop.len, 1'b0};
      end else begin
        rem = d_rem[j-1];
        low = d_low[j-1];
        q   = d_q[j-1];
        den = {d_wop[j-1].len, 1'b0};
      end
      for (int s = 0; s < DIV_PER_STAGE; s++) begin
        r   = {rem, low[TIME_W-1]};
        low = {low[TIME_W-2:0], 1'b0};
        if (r >= {1'b0, den}) begin
          r = r - {1'b0, den};
          q = {q[WGT_W-2:0], 1'b1};
        end else begin
          q = {q[WGT_W-2:0], 1'b0};
        end
        rem = r[DEN_W-1:0];
      end
      rem_next[j] = rem;
      low_next[j] = low;
      q_next[j]   = q;
    end
    if (d_wop[LAST].bypass) begin
      w_next = d_wop[LAST].base;
    end else if (d_wop[LAST].dir) begin
      w_next = d_wop[LAST].base + d_q[LAST];
    end else begin
      w_next = d_wop[LAST].base - d_q[LAST];
    end
    wb_upd    = en && d_valid[LAST] && d_wop[LAST].upd;
    wb_weight = w_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      for (int j = 0; j < DIV_STAGES; j++) begin
        d_valid[j] <= 1'b0;
      end
      w_valid <= 1'b0;
    end else if (en) begin
      p_valid    <= s1_valid;
      d_valid[0] <= p_valid;
      for (int j = 1; j < DIV_STAGES; j++) begin
        d_valid[j] <= d_valid[j-1];
      end
      w_valid <= d_valid[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wop    <= s1_wop;
      p_bone   <= s1_bone;
      p_prod   <= s1_wop.d * s1_wop.e;
      d_wop[0]  <= p_wop;
      d_bone[0] <= p_bone;
      for (int j = 1; j < DIV_STAGES; j++) begin
        d_wop[j]  <= d_wop[j-1];
        d_bone[j] <= d_bone[j-1];
      end
      for (int j = 0; j < DIV_STAGES; j++) begin
        d_rem[j] <= rem_next[j];
        d_low[j] <= low_next[j];
        d_q[j]   <= q_next[j];
      end
      w_weight <= w_next;
      w_bone   <= d_bone[LAST];
    end
  end

endmodule

/* sv/pbr_lerp.sv */
// Lerp of translation, scale and rotation with the shortest-arc sign flip.
`timescale 1ns / 1ps
module pbr_lerp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  w_valid,
  input  logic [pbr_pkg::WGT_W-1:0]             w_weight,
  input  pbr_pkg::bone_t                        w_bone,
  output logic                                  l_valid,
  output pbr_pkg::res_t                         l_res,
  output logic [3:0][pbr_pkg::C_W-1:0]          l_c
);
  import pbr_pkg::*;

  localparam int TB = TRANSLATION_BITS;
  localparam int RB = ROTATION_BITS;
  localparam int SB = SCALE_BITS;

  logic                   l1_valid, l2_valid, l3_valid, l4_valid;
  logic [WGT_W-1:0]       l1_w, l2_w;
  bone_t                  l1_bone, l2_bone;
  logic [3:0][DP_W-1:0]   l1_dp;
  logic [2:0][DT_W-1:0]   l1_dt;
  logic [2:0][DS_W-1:0]   l1_ds;
  logic                   l2_neg;
  logic [2:0][PRD_W-1:0]  l2_pt;
  logic [2:0][PRD_W-1:0]  l2_ps;
  res_t                   l3_res, l4_res;
  logic [ROT_W-1:0]       l3_arot, l4_arot;
  logic [3:0][DR_W-1:0]   l3_dr;
  logic [3:0][PRD_W-1:0]  l4_pr;

  logic                   neg_next;
  res_t                   res_next;
  logic [3:0][DR_W-1:0]   dr_next;
  logic [3:0][C_W-1:0]    c_next;

  always_comb begin
    logic signed [DP_W+1:0]  dsum;
    logic signed [PRD_W-1:0] sum;
    logic signed [DR_W-1:0]  bb;
    dsum = '0;
    for (int i = 0; i < 4; i++) begin
      dsum = dsum + (DP_W + 2)'($signed(l1_dp[i]));
    end
    neg_next = dsum[DP_W+1];

    res_next.mode      = l2_bone.mode;
    res_next.frame_end = l2_bone.frame_end;
    res_next.weight    = l2_w;
    res_next.trn       = '0;
    res_next.scl       = '0;
    for (int i = 0; i < 3; i++) begin
      sum = PRD_W'($signed(l2_bone.a_trn[i*TB +: TB])) + round_q15($signed(l2_pt[i]));
      res_next.trn[i*TB +: TB] = sum[TB-1:0];
      sum = PRD_W'($signed(l2_bone.a_scl[i*SB +: SB])) + round_q15($signed(l2_ps[i]));
      res_next.scl[i*SB +: SB] = sum[SB-1:0];
    end
    for (int i = 0; i < 4; i++) begin
      bb = DR_W'($signed(l2_bone.b_rot[i*RB +: RB]));
      if (l2_neg) begin
        bb = -bb;
      end
      dr_next[i] = bb - DR_W'($signed(l2_bone.a_rot[i*RB +: RB]));
    end
    for (int i = 0; i < 4; i++) begin
      sum = PRD_W'($signed(l4_arot[i*RB +: RB])) + round_q15($signed(l4_pr[i]));
      c_next[i] = sum[C_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_valid <= 1'b0;
      l2_valid <= 1'b0;
      l3_valid <= 1'b0;
      l4_valid <= 1'b0;
      l_valid  <= 1'b0;
    end else if (en) begin
      l1_valid <= w_valid;
      l2_valid <= l1_valid;
      l3_valid <= l2_valid;
      l4_valid <= l3_valid;
      l_valid  <= l4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1_w    <= w_weight;
      l1_bone <= w_bone;
      for (int i = 0; i < 3; i++) begin
        l1_dt[i] <= DT_W'($signed(w_bone.b_trn[i*TB +: TB]))
                  - DT_W'($signed(w_bone.a_trn[i*TB +: TB]));
        l1_ds[i] <= DS_W'($signed(w_bone.b_scl[i*SB +: SB]))
                  - DS_W'($signed(w_bone.a_scl[i*SB +: SB]));
      end
      for (int i = 0; i < 4; i++) begin
        l1_dp[i] <= $signed(w_bone.a_rot[i*RB +: RB]) * $signed(w_bone.b_rot[i*RB +: RB]);
      end

      l2_w    <= l1_w;
      l2_bone <= l1_bone;
      l2_neg  <= neg_next;
      for (int i = 0; i < 3; i++) begin
        l2_pt[i] <= $signed(l1_dt[i]) * $signed({1'b0, l1_w});
        l2_ps[i] <= $signed(l1_ds[i]) * $signed({1'b0, l1_w});
      end

      l3_res  <= res_next;
      l3_arot <= l2_bone.a_rot;
      l3_dr   <= dr_next;

      l4_res  <= l3_res;
      l4_arot <= l3_arot;
      for (int i = 0; i < 4; i++) begin
        l4_pr[i] <= $signed(l3_dr[i]) * $signed({1'b0, l3_res.weight});
      end

      l_res <= l4_res;
      l_c   <= c_next;
    end
  end

endmodule

/* sv/pbr_qnorm.sv */
// Quaternion normalization: exact rounded c*U/|c| found one bit per stage.
`timescale 1ns / 1ps
module pbr_qnorm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          l_valid,
  input  pbr_pkg::res_t                 l_res,
  input  logic [3:0][pbr_pkg::C_W-1:0]  l_c,
  output logic                          q_valid,
  output pbr_pkg::res_t                 q_res,
  output logic [pbr_pkg::ROT_W-1:0]     q_rot
);
  import pbr_pkg::*;

  localparam int RB = ROTATION_BITS;

  typedef struct packed {
    logic              neg;
    logic [CAND_W-1:0] rhs;
    logic [CAND_W-1:0] s;
    logic [CAND_W-1:0] p;
    logic [Q_W-1:0]    q;
  } lane_t;

  logic                  n1_valid;
  res_t                  n1_res;
  logic [3:0][SQ_W-1:0]  n1_sq;
  logic [3:0]            n1_neg;

  logic                  st_valid [NORM_STEPS+1];
  res_t                  st_res   [NORM_STEPS+1];
  logic [N2_W-1:0]       st_n2    [NORM_STEPS+1];
  lane_t                 st_lane  [NORM_STEPS+1][4];

  lane_t                 lane_next [NORM_STEPS+1][4];
  logic [N2_W-1:0]       n2_next;
  logic [ROT_W-1:0]      rot_next;

  // Each lane keeps S = (2q-1)^2 * n2 and P = (2q-1) * n2, so trying one more
  // bit of q takes only shifts and adds. The accepted q is the largest one up
  // to U with (2q-1)^2 * n2 <= 4 * c^2 * U^2.
  always_comb begin
    logic [Q_W-1:0]           unit;
    logic [Q_W-1:0]           try_q;
    logic signed [CAND_W-1:0] n2e;
    logic signed [CAND_W-1:0] cand;
    logic [N2_W-1:0]          n2;
    int                       k;
    unit    = Q_W'(1) << UNIT_SH;
    n2_next = '0;
    for (int i = 0; i < 4; i++) begin
      n2_next = n2_next + N2_W'(n1_sq[i]);
    end
    n2e = CAND_W'(n2_next);
    for (int i = 0; i < 4; i++) begin
      lane_next[0][i].neg = n1_neg[i];
      lane_next[0][i].rhs = CAND_W'(n1_sq[i]) << (2 * UNIT_SH + 2);
      lane_next[0][i].s   = n2e;
      lane_next[0][i].p   = -n2e;
      lane_next[0][i].q   = '0;
    end
    for (int j = 1; j <= NORM_STEPS; j++) begin
      k   = NORM_STEPS - j;
      n2  = st_n2[j-1];
      n2e = CAND_W'(n2);
      for (int i = 0; i < 4; i++) begin
        lane_next[j][i] = st_lane[j-1][i];
        try_q = st_lane[j-1][i].q | (Q_W'(1) << k);
        cand  = $signed(st_lane[j-1][i].s) + ($signed(st_lane[j-1][i].p) <<< (k + 2))
              + (n2e <<< (2 * k + 2));
        if (try_q <= unit && cand <= $signed(st_lane[j-1][i].rhs)) begin
          lane_next[j][i].q = try_q;
          lane_next[j][i].s = cand;
          lane_next[j][i].p = $signed(st_lane[j-1][i].p) + (n2e <<< (k + 1));
        end
      end
    end
    // An all-zero blend gives the identity quaternion.
    for (int i = 0; i < 4; i++) begin
      if (st_n2[NORM_STEPS] == '0) begin
        rot_next[i*RB +: RB] = (i == 3) ? RB'(unit) : '0;
      end else if (st_lane[NORM_STEPS][i].neg) begin
        rot_next[i*RB +: RB] = -RB'(st_lane[NORM_STEPS][i].q);
      end else begin
        rot_next[i*RB +: RB] = RB'(st_lane[NORM_STEPS][i].q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_valid <= 1'b0;
      for (int j = 0; j <= NORM_STEPS; j++) begin
        st_valid[j] <= 1'b0;
      end
      q_valid <= 1'b0;
    end else if (en) begin
      n1_valid    <= l_valid;
      st_valid[0] <= n1_valid;
      for (int j = 1; j <= NORM_STEPS; j++) begin
        st_valid[j] <= st_valid[j-1];
      end
      q_valid <= st_valid[NORM_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_res <= l_res;
      for (int i = 0; i < 4; i++) begin
        n1_sq[i]  <= $signed(l_c[i]) * $signed(l_c[i]);
        n1_neg[i] <= l_c[i][C_W-1];
      end
      st_res[0] <= n1_res;
      st_n2[0]  <= n2_next;
      for (int j = 1; j <= NORM_STEPS; j++) begin
        st_res[j] <= st_res[j-1];
        st_n2[j]  <= st_n2[j-1];
      end
      for (int j = 0; j <= NORM_STEPS; j++) begin
        for (int i = 0; i < 4; i++) begin
          st_lane[j][i] <= lane_next[j][i];
        end
      end
      q_res <= st_res[NORM_STEPS];
      q_rot <= rot_next;
    end
  end

endmodule

/* sv/pose_blend_ramp.sv */
// Top level of the ramped animation and physics pose blender.
//
//  channel   valid      stall      payload
//  request   req_valid  req_stall  command, enable, duration_ms, delta_ms, anim_*, rag_*,
//                                  last_bone
//  result    res_valid  res_stall  out_translation, out_rotation, out_scale, mode, weight,
//                                  frame_end
//
// One request per cycle unless req_stall is high; a bone's result passes through one control
// stage, the 16-bit weight divider (product, eight stages and the weight register), five
// lerp stages and the quaternion normalizer (one stage per result bit plus setup and output).
// A start command makes no result and waits until every
// frame-advancing bone has passed the divider.
// Reset is synchronous and clears the ramp state and all stage valid bits.
// A stalled result freezes the whole pipeline in place.
`timescale 1ns / 1ps
module pose_blend_ramp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic                         command,
  input  logic                         enable,
  input  logic [pbr_pkg::TIME_W-1:0]   duration_ms,
  input  logic [pbr_pkg::DELTA_W-1:0]  delta_ms,
  input  logic [pbr_pkg::TRN_W-1:0]    anim_translation,
  input  logic [pbr_pkg::ROT_W-1:0]    anim_rotation,
  input  logic [pbr_pkg::SCL_W-1:0]    anim_scale,
  input  logic [pbr_pkg::TRN_W-1:0]    rag_translation,
  input  logic [pbr_pkg::ROT_W-1:0]    rag_rotation,
  input  logic [pbr_pkg::SCL_W-1:0]    rag_scale,
  input  logic                         last_bone,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [pbr_pkg::TRN_W-1:0]    out_translation,
  output logic [pbr_pkg::ROT_W-1:0]    out_rotation,
  output logic [pbr_pkg::SCL_W-1:0]    out_scale,
  output logic [1:0]                   mode,
  output logic [pbr_pkg::WGT_W-1:0]    weight,
  output logic                         frame_end
);
  import pbr_pkg::*;

  logic                  en;
  bone_t                 bone_in;
  logic                  s1_valid;
  wop_t                  s1_wop;
  bone_t                 s1_bone;
  logic                  wb_upd;
  logic [WGT_W-1:0]      wb_weight;
  logic                  w_valid;
  logic [WGT_W-1:0]      w_weight;
  bone_t                 w_bone;
  logic                  l_valid;
  res_t                  l_res;
  logic [3:0][C_W-1:0]   l_c;
  res_t                  q_res;

  assign en = !(res_valid && res_stall);

  always_comb begin
    bone_in.a_trn     = anim_translation;
    bone_in.a_rot     = anim_rotation;
    bone_in.a_scl     = anim_scale;
    bone_in.b_trn     = rag_translation;
    bone_in.b_rot     = rag_rotation;
    bone_in.b_scl     = rag_scale;
    bone_in.mode      = MODE_ANIM;
    bone_in.frame_end = last_bone;
  end

  pbr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .command     (command),
    .enable      (enable),
    .duration_ms (duration_ms),
    .delta_ms    (delta_ms),
    .last_bone   (last_bone),
    .bone_in     (bone_in),
    .wb_upd      (wb_upd),
    .wb_weight   (wb_weight),
    .s1_valid    (s1_valid),
    .s1_wop      (s1_wop),
    .s1_bone     (s1_bone)
  );

  pbr_wdiv u_wdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .s1_valid  (s1_valid),
    .s1_wop    (s1_wop),
    .s1_bone   (s1_bone),
    .w_valid   (w_valid),
    .w_weight  (w_weight),
    .w_bone    (w_bone),
    .wb_upd    (wb_upd),
    .wb_weight (wb_weight)
  );

  pbr_lerp u_lerp (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .w_valid  (w_valid),
    .w_weight (w_weight),
    .w_bone   (w_bone),
    .l_valid  (l_valid),
    .l_res    (l_res),
    .l_c      (l_c)
  );

  pbr_qnorm u_qnorm (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .l_valid (l_valid),
    .l_res   (l_res),
    .l_c     (l_c),
    .q_valid (res_valid),
    .q_res   (q_res),
    .q_rot   (out_rotation)
  );

  assign out_translation = q_res.trn;
  assign out_scale       = q_res.scl;
  assign mode            = q_res.mode;
  assign weight          = q_res.weight;
  assign frame_end       = q_res.frame_end;

endmodule
